// File: hw/rtl/msf_pkg.sv
// msf_pkg: shared types, codes and rate tables for the mp3 stream framer
// depends on nothing

package msf_pkg;

  localparam int unsigned WindowBytesDef = 10;
  localparam int unsigned LenW = 29;

  typedef enum logic [1:0] {
    KIND_SKIP  = 2'd0,
    KIND_ID3V2 = 2'd1,
    KIND_ID3V1 = 2'd2,
    KIND_AUDIO = 2'd3
  } seg_kind_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_EVAL,
    ST_DIV,
    ST_EMIT
  } ctl_state_t;

  // controller to datapath
  typedef struct packed {
    logic      load;      // write accepted byte into window
    logic      eval;      // judge window head
    logic      div_start; // begin frame length division
    logic      div_step;  // one restoring step
    logic      emit;      // release head byte
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic      empty;
    logic      in_seg;
    logic      wait_more; // head needs more lookahead
    logic      need_div;  // valid audio header, length pending
    logic      div_done;
    logic      last_held; // only one byte held
  } dp_sts_t;

  localparam logic [7:0] ChI = 8'h49;
  localparam logic [7:0] ChD = 8'h44;
  localparam logic [7:0] Ch3 = 8'h33;
  localparam logic [7:0] ChT = 8'h54;
  localparam logic [7:0] ChA = 8'h41;
  localparam logic [7:0] ChG = 8'h47;
  localparam logic [7:0] ChFF = 8'hFF;

  function automatic logic [8:0] rate_kbps(input logic v1, input logic [1:0] lay,
                                           input logic [3:0] bri);
    logic [8:0] r;
    r = 9'd0;
    if (v1) begin
      case (lay)
        2'd1: case (bri)
            4'd1: r = 9'd32;   4'd2: r = 9'd64;   4'd3: r = 9'd96;   4'd4: r = 9'd128;
            4'd5: r = 9'd160;  4'd6: r = 9'd192;  4'd7: r = 9'd224;  4'd8: r = 9'd256;
            4'd9: r = 9'd288;  4'd10: r = 9'd320; 4'd11: r = 9'd352; 4'd12: r = 9'd384;
            4'd13: r = 9'd416; 4'd14: r = 9'd448; default: r = 9'd0;
          endcase
        2'd2: case (bri)
            4'd1: r = 9'd32;   4'd2: r = 9'd48;   4'd3: r = 9'd56;   4'd4: r = 9'd64;
            4'd5: r = 9'd80;   4'd6: r = 9'd96;   4'd7: r = 9'd112;  4'd8: r = 9'd128;
            4'd9: r = 9'd160;  4'd10: r = 9'd192; 4'd11: r = 9'd224; 4'd12: r = 9'd256;
            4'd13: r = 9'd320; 4'd14: r = 9'd384; default: r = 9'd0;
          endcase
        default: case (bri)
            4'd1: r = 9'd32;   4'd2: r = 9'd40;   4'd3: r = 9'd48;   4'd4: r = 9'd56;
            4'd5: r = 9'd64;   4'd6: r = 9'd80;   4'd7: r = 9'd96;   4'd8: r = 9'd112;
            4'd9: r = 9'd128;  4'd10: r = 9'd160; 4'd11: r = 9'd192; 4'd12: r = 9'd224;
            4'd13: r = 9'd256; 4'd14: r = 9'd320; default: r = 9'd0;
          endcase
      endcase
    end else begin
      if (lay == 2'd1) begin
        case (bri)
          4'd1: r = 9'd32;   4'd2: r = 9'd48;   4'd3: r = 9'd56;   4'd4: r = 9'd64;
          4'd5: r = 9'd80;   4'd6: r = 9'd96;   4'd7: r = 9'd112;  4'd8: r = 9'd128;
          4'd9: r = 9'd144;  4'd10: r = 9'd160; 4'd11: r = 9'd176; 4'd12: r = 9'd192;
          4'd13: r = 9'd224; 4'd14: r = 9'd256; default: r = 9'd0;
        endcase
      end else begin
        case (bri)
          4'd1: r = 9'd8;    4'd2: r = 9'd16;   4'd3: r = 9'd24;   4'd4: r = 9'd32;
          4'd5: r = 9'd40;   4'd6: r = 9'd48;   4'd7: r = 9'd56;   4'd8: r = 9'd64;
          4'd9: r = 9'd80;   4'd10: r = 9'd96;  4'd11: r = 9'd112; 4'd12: r = 9'd128;
          4'd13: r = 9'd144; 4'd14: r = 9'd160; default: r = 9'd0;
        endcase
      end
    end
    return r;
  endfunction

  function automatic logic [15:0] sample_hz(input logic [1:0] ver, input logic [1:0] sri);
    logic [15:0] s;
    s = 16'd0;
    case (ver)
      2'd3: case (sri)
          2'd0: s = 16'd44100; 2'd1: s = 16'd48000; default: s = 16'd32000;
        endcase
      2'd2: case (sri)
          2'd0: s = 16'd22050; 2'd1: s = 16'd24000; default: s = 16'd16000;
        endcase
      default: case (sri)
          2'd0: s = 16'd11025; 2'd1: s = 16'd12000; default: s = 16'd8000;
        endcase
    endcase
    return s;
  endfunction

endpackage

// File: hw/rtl/msf_ctrl.sv
// msf_ctrl: sequencing state machine of the mp3 stream framer
// depends on msf_pkg

module msf_ctrl import msf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     slot_free,
  input  dp_sts_t  sts,
  output dp_cmd_t  cmd,
  output logic     push
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_LOAD;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    push = 1'b0;
    in_stall = (state_r != ST_LOAD);
    case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (sts.empty || (!sts.in_seg && sts.wait_more)) begin
          state_nxt = ST_LOAD;
        end else if (!sts.in_seg && sts.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt = ST_DIV;
        end else begin
          cmd.eval = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // segment start already latched, release head when output slot is free
        if (slot_free) begin
          cmd.emit = 1'b1;
          push = 1'b1;
          state_nxt = sts.last_held ? ST_LOAD : ST_EVAL;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

`ifndef SYNTH
  a_no_load_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_LOAD |-> in_stall) else $error("input taken while busy");
  a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> slot_free) else $error("emit into full slot");
  a_div_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && sts.div_done) |=> state_r == ST_EMIT)
    else $error("division result lost");
`endif

endmodule

// File: hw/rtl/msf_dp.sv
// msf_dp: lookahead window, header checks, segment counters and length divider
// depends on msf_pkg

module msf_dp import msf_pkg::*; #(
  parameter int unsigned WINDOW_BYTES = WindowBytesDef
) (
  input  logic            clk,
  input  logic            rst_n,
  input  dp_cmd_t         cmd,
  input  logic [7:0]      in_data_byte,
  output dp_sts_t         sts,
  output logic [7:0]      head_byte,
  output logic [1:0]      emit_kind,
  output logic            emit_first,
  output logic            emit_last,
  output logic [LenW-1:0] emit_len,
  output logic            emit_run_end
);

  localparam int unsigned CntW = $clog2(WINDOW_BYTES + 1);
  localparam int unsigned IdxW = $clog2(WINDOW_BYTES);
  localparam logic [CntW-1:0] Full = CntW'(WINDOW_BYTES);
  localparam logic [CntW-1:0] One = CntW'(1);

  logic [7:0]      win_r [WINDOW_BYTES];
  logic [CntW-1:0] cnt_r;
  logic            in_seg_r;
  logic [1:0]      kind_r;
  logic [LenW-1:0] rem_r, len_r;

  // divider: quotient of 18-bit-scaled numerator by sample rate
  logic [27:0] num_r;
  logic [15:0] den_r;
  logic [16:0] part_r;
  logic [27:0] quo_r;
  logic [4:0]  step_r;
  logic        lay1_r, pad_r;

  assign head_byte = win_r[0];

  logic [7:0] b1, b2;
  logic [1:0] ver, layb;
  logic [3:0] bri;
  logic [1:0] sri;
  logic       audio_ok;
  logic       id3_ok, tag_ok;
  logic [LenW-1:0] id3_len;
  logic [8:0] br;
  logic [17:0] mulc;

  always_comb begin
    b1 = win_r[1];
    b2 = win_r[2];
    ver = b1[4:3];
    layb = b1[2:1];
    bri = b2[7:4];
    sri = b2[3:2];
    audio_ok = (b1[7:5] == 3'b111) && (ver != 2'd1) && (layb != 2'd0) &&
               (bri != 4'd0) && (bri != 4'd15) && (sri != 2'd3);
    // layer number: 4 - layb, encoded 1..3
    br = rate_kbps(ver == 2'd3, 2'd3 - (layb - 2'd1), bri);
    if (layb == 2'd3)      mulc = 18'd12000;
    else if (layb == 2'd1 && ver != 2'd3) mulc = 18'd72000;
    else                   mulc = 18'd144000;
    id3_ok = (win_r[1] == ChD) && (win_r[2] == Ch3) &&
             !(win_r[6][7] | win_r[7][7] | win_r[8][7] | win_r[9][7]);
    id3_len = LenW'({win_r[6][6:0], win_r[7][6:0], win_r[8][6:0], win_r[9][6:0]}) +
              LenW'(10) + (win_r[5][4] ? LenW'(10) : LenW'(0));
    tag_ok = (win_r[1] == ChA) && (win_r[2] == ChG);
  end

  always_comb begin
    sts.empty = (cnt_r == '0);
    sts.in_seg = in_seg_r;
    sts.last_held = (cnt_r == One);
    sts.wait_more = 1'b0;
    sts.need_div = 1'b0;
    if (win_r[0] == ChI)       sts.wait_more = cnt_r < CntW'(10);
    else if (win_r[0] == ChT)  sts.wait_more = cnt_r < CntW'(3);
    else if (win_r[0] == ChFF) begin
      sts.wait_more = cnt_r < CntW'(4);
      sts.need_div = !sts.wait_more && audio_ok;
    end
    sts.div_done = (step_r == 5'd0);
  end

  logic [16:0] trial;
  logic [LenW-1:0] alen;
  always_comb begin
    trial = {part_r[15:0], num_r[27]} - {1'b0, den_r};
    alen = lay1_r ? LenW'({quo_r[26:0], 2'b00} + {pad_r, 2'b00})
                  : LenW'(quo_r) + LenW'(pad_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load && cnt_r != Full) win_r[cnt_r[IdxW-1:0]] <= in_data_byte;
    if (cmd.div_start) begin
      num_r <= 28'(mulc) * 28'(br);
      den_r <= sample_hz(ver, sri);
      part_r <= '0;
      quo_r <= '0;
      lay1_r <= (layb == 2'd3);
      pad_r <= b2[1];
    end else if (cmd.div_step && step_r != 5'd0) begin
      if (!trial[16]) part_r <= trial;
      else            part_r <= {part_r[15:0], num_r[27]};
      quo_r <= {quo_r[26:0], !trial[16]};
      num_r <= {num_r[26:0], 1'b0};
    end
    if (cmd.eval && !in_seg_r) begin
      if (win_r[0] == ChI && id3_ok) begin
        kind_r <= KIND_ID3V2; len_r <= id3_len; rem_r <= id3_len;
      end else if (win_r[0] == ChT && tag_ok) begin
        kind_r <= KIND_ID3V1; len_r <= LenW'(128); rem_r <= LenW'(128);
      end else begin
        kind_r <= KIND_SKIP; len_r <= LenW'(1); rem_r <= LenW'(1);
      end
    end else if (cmd.div_step && step_r == 5'd0) begin
      kind_r <= KIND_AUDIO; len_r <= alen; rem_r <= alen;
    end else if (cmd.emit && rem_r != '0) begin
      rem_r <= rem_r - LenW'(1);
    end
    if (cmd.emit) begin
      for (int i = 0; i < WINDOW_BYTES - 1; i++) win_r[i] <= win_r[i + 1];
      win_r[WINDOW_BYTES-1] <= '0;
    end
  end

  logic [CntW-1:0] cnt_after;
  logic            next_waits;
  always_comb begin
    emit_kind = kind_r;
    emit_first = (rem_r == len_r);
    emit_last = (rem_r <= LenW'(1));
    emit_len = len_r;
    cnt_after = cnt_r - One;
    next_waits = 1'b0;
    if (win_r[1] == ChI)       next_waits = cnt_after < CntW'(10);
    else if (win_r[1] == ChT)  next_waits = cnt_after < CntW'(3);
    else if (win_r[1] == ChFF) next_waits = cnt_after < CntW'(4);
    // run ends when the window drains or, at a segment's last byte, the next head has to wait for lookahead
    emit_run_end = (cnt_after == '0) || ((rem_r <= LenW'(1)) && next_waits);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      in_seg_r <= 1'b0;
      step_r <= '0;
    end else begin
      if (cmd.load && cnt_r != Full) cnt_r <= cnt_r + One;
      else if (cmd.emit)             cnt_r <= cnt_r - One;
      if (cmd.div_start) step_r <= 5'd28;
      else if (cmd.div_step && step_r != 5'd0) step_r <= step_r - 5'd1;
      if ((cmd.eval && !in_seg_r) || (cmd.div_step && step_r == 5'd0)) in_seg_r <= 1'b1;
      else if (cmd.emit && rem_r <= LenW'(1)) in_seg_r <= 1'b0;
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Full) else $error("window count overflow");
  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> cnt_r != '0) else $error("emit from empty window");
  a_emit_in_seg: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> in_seg_r) else $error("emit outside segment");
`endif

endmodule

// File: hw/rtl/mp3_stream_framer_core.sv
// mp3_stream_framer_core: top level of the mp3 stream framer
// depends on msf_pkg, msf_ctrl, msf_dp

// Byte-serial MPEG audio framer: each accepted byte enters a lookahead window
// and every byte leaves exactly once, in order, tagged with its segment
// (skipped, ID3v2, ID3v1, audio frame). A byte is loaded in ST_LOAD, then the
// window head is judged in ST_EVAL and each released byte goes out in
// ST_EMIT; the input is stalled outside ST_LOAD. An audio header adds a
// restoring division of bitrate times scale by sample rate in ST_DIV, and a
// stalled output holds the release. Bytes still held at end of stream stay
// in the window. No memory clearing pass is needed.

module mp3_stream_framer_core import msf_pkg::*; #(
  parameter int unsigned WINDOW_BYTES = WindowBytesDef
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_data_byte,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_out_byte,
  output logic [1:0]      out_segment_kind,
  output logic            out_segment_first,
  output logic            out_segment_last,
  output logic [LenW-1:0] out_segment_length,
  output logic            out_last_of_run
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic push, slot_free;
  logic [7:0] hb;
  logic [1:0] ek;
  logic ef, el, erun;
  logic [LenW-1:0] elen;
  logic out_valid_r;

  assign slot_free = !out_valid_r || !out_stall;

  msf_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .slot_free, .sts, .cmd, .push
  );

  msf_dp #(.WINDOW_BYTES(WINDOW_BYTES)) u_dp (
    .clk, .rst_n, .cmd, .in_data_byte, .sts, .head_byte(hb),
    .emit_kind(ek), .emit_first(ef), .emit_last(el), .emit_len(elen),
    .emit_run_end(erun)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (push) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_out_byte <= hb;
      out_segment_kind <= ek;
      out_segment_first <= ef;
      out_segment_last <= el;
      out_segment_length <= elen;
      // run ends when window drains, or when the segment ends and next head would wait
      out_last_of_run <= erun;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid) else $error("request dropped");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> slot_free) else $error("result overwritten");
  a_single_side: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !push) else $error("load during release");
`endif

endmodule
